// ===== src/bsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsvc_pkg
// types and constants shared by the bounding-sphere view cull block
// ----------------------------------------------------------------------------
package bsvc_pkg;

    // input beat: one view-space object
    typedef struct packed {
        logic               new_sector;
        logic [1:0]         obj_type;
        logic               needs_transform;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic [30:0]        radius;
    } t_in_beat;

    // output beat: cull decision for one object
    typedef struct packed {
        logic       accepted;
        logic [6:0] slot;
        logic [2:0] verdict;
        logic [7:0] kept_count;
    } t_out_beat;

    // object types
    localparam logic [1:0] OBJ_SPRITE = 2'd0;
    localparam logic [1:0] OBJ_FRAME  = 2'd1;
    localparam logic [1:0] OBJ_MODEL  = 2'd2;

    // verdict codes
    localparam logic [2:0] V_KEPT    = 3'd0;
    localparam logic [2:0] V_UNFLAG  = 3'd1;
    localparam logic [2:0] V_NEAR    = 3'd2;
    localparam logic [2:0] V_LEFT    = 3'd3;
    localparam logic [2:0] V_RIGHT   = 3'd4;
    localparam logic [2:0] V_WRIGHT  = 3'd5;
    localparam logic [2:0] V_WLEFT   = 3'd6;
    localparam logic [2:0] V_FULL    = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_FOCAL = 2'd0;
    localparam logic [1:0] CFG_XMID  = 2'd1;
    localparam logic [1:0] CFG_WMIN  = 2'd2;
    localparam logic [1:0] CFG_WMAX  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // configuration reset values
    localparam logic [30:0] FOCAL_RST = 31'd10485760;
    localparam logic [11:0] XMID_RST  = 12'd160;
    localparam logic [11:0] WMIN_RST  = 12'd0;
    localparam logic [11:0] WMAX_RST  = 12'd319;

    // 1.0 in 16.16
    localparam logic signed [31:0] ONE_FIX = 32'sd65536;

    // radix-2 divider: 48-bit dividend, one quotient bit per cycle
    localparam int DIV_W = 48;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

endpackage

// ===== src/bounding_sphere_view_cull.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_view_cull
// bounding-sphere frustum and window cull for view-space objects
// ----------------------------------------------------------------------------
// one object beat enters on the input channel (i_in_valid / o_in_ready) and
// one decision beat leaves on the output channel (o_out_valid / i_out_ready).
// the block works on one object at a time: o_in_ready is high only while the
// sequencer is idle.
// sprites, frames, unflagged, full-sector, plane-rejected and near-plane
// straddling objects pass from S_PREP through S_TEST straight to S_FIN. a model
// that needs projection runs both x extents through one shared 32x32 multiplier
// and one shared radix-2 divider (one quotient bit a cycle, 48 bits), each extent
// via S_MUL, S_DSET, S_DIV, S_QFIX and S_CMP; the right extent is skipped when
// the left extent already rejects. S_FIN raises output valid and returns to
// idle, where the next object is taken.
// the decision sits in an output register; the sequencer takes the next
// object while it waits, and stalls at its last step only when the register
// still holds an untaken beat.
// reset (i_rst_n low, synchronous) holds o_in_ready low, clears the sector
// count, empties the output register and restores the default focal length
// and window. configuration writes (i_cfg_we) take effect at once and are
// meant for idle periods.
// ----------------------------------------------------------------------------
module bounding_sphere_view_cull #(
    parameter int MAX_OBJECTS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsvc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsvc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bsvc_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bsvc_pkg::t_out_beat            o_out_data
);
    import bsvc_pkg::*;

    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBJECTS);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_TEST = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_DSET = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_QFIX = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    // control state
    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [30:0]       r_focal;
    logic [11:0]       r_xmid;
    logic [11:0]       r_wmin;
    logic [11:0]       r_wmax;

    // datapath
    t_in_beat           r_in;
    logic signed [31:0] r_z_max;
    logic signed [31:0] r_x_max;
    logic signed [31:0] r_x_min;
    logic signed [31:0] r_z_min;
    logic               r_ext;
    logic [31:0]        r_p;
    logic [31:0]        r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [31:0]        r_dvs;
    logic               r_neg;
    logic [STEP_W-1:0]  r_step;
    logic [31:0]        r_q;
    logic [2:0]         r_verdict;
    t_out_beat          r_out;

    logic               in_fire;
    logic               out_fire;
    logic               fin_go;
    logic signed [31:0] rad_s;
    logic signed [31:0] neg_zmax;
    logic               full;
    logic               test_done;
    logic [2:0]         test_verdict;
    logic signed [31:0] ext_val;
    logic signed [31:0] focal_s;
    logic signed [63:0] prod;
    logic [31:0]        p_mag;
    logic [31:0]        z_mag;
    logic [32:0]        trial;
    logic               take;
    logic [31:0]        qw;
    logic [31:0]        rnd;
    logic signed [17:0] col;
    logic signed [17:0] wmin_s;
    logic signed [17:0] wmax_s;
    logic [CNT_W-1:0]   n_count;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_fire    = r_out_valid && i_out_ready;
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // plane tests
    assign rad_s    = $signed({1'b0, r_in.radius});
    assign neg_zmax = -r_z_max;
    assign full     = (r_count >= CNT_MAX);

    always_comb begin
        test_done    = 1'b1;
        test_verdict = V_KEPT;
        if (full) begin
            test_verdict = V_FULL;
        end else if (!r_in.needs_transform) begin
            test_verdict = V_UNFLAG;
        end else if (r_in.obj_type inside {OBJ_SPRITE, OBJ_FRAME}) begin
            test_verdict = (r_in.pos_z >= ONE_FIX) ? V_KEPT : V_NEAR;
        end else if (r_in.obj_type != OBJ_MODEL) begin
            test_verdict = V_UNFLAG;
        end else if (r_z_max < ONE_FIX) begin
            test_verdict = V_NEAR;
        end else if (r_x_max < neg_zmax) begin
            test_verdict = V_LEFT;
        end else if (r_x_min > r_z_max) begin
            test_verdict = V_RIGHT;
        end else if (r_z_min <= 32'sd0) begin
            // straddles the near plane
            test_verdict = V_KEPT;
        end else begin
            test_done = 1'b0;
        end
    end

    // projection: shared multiplier
    assign ext_val = r_ext ? r_x_max : r_x_min;
    assign focal_s = $signed({1'b0, r_focal});
    assign prod    = ext_val * focal_s;

    // divider operands as magnitudes
    assign p_mag = r_p[31] ? (32'd0 - r_p) : r_p;
    assign z_mag = r_in.pos_z[31] ? (32'd0 - 32'(r_in.pos_z)) : 32'(r_in.pos_z);

    // restoring divider step
    assign trial = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_dvs};
    assign take  = !trial[32];

    // sign fix, zero depth gives zero
    always_comb begin
        if (r_dvs == 32'd0) begin
            qw = 32'd0;
        end else if (r_neg) begin
            qw = 32'd0 - r_quo[31:0];
        end else begin
            qw = r_quo[31:0];
        end
    end

    // round to a column and add the view centre
    assign rnd    = r_q + 32'h0000_8000;
    assign col    = $signed({{2{rnd[31]}}, rnd[31:16]}) + $signed({6'b0, r_xmid});
    assign wmin_s = $signed({6'b0, r_wmin});
    assign wmax_s = $signed({6'b0, r_wmax});

    assign n_count = r_count + CNT_W'(1);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_focal     <= FOCAL_RST;
            r_xmid      <= XMID_RST;
            r_wmin      <= WMIN_RST;
            r_wmax      <= WMAX_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FOCAL: r_focal <= i_cfg_data[30:0];
                    CFG_XMID:  r_xmid  <= i_cfg_data[11:0];
                    CFG_WMIN:  r_wmin  <= i_cfg_data[11:0];
                    CFG_WMAX:  r_wmax  <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end

            // a new decision beat replaces the one taken this cycle
            if (out_fire && !fin_go) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.new_sector) begin
                            r_count <= '0;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_state <= test_done ? S_FIN : S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == DIV_LAST) begin
                        r_state <= S_QFIX;
                    end
                end
                S_QFIX: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_ext && !(col > wmax_s)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out_valid <= 1'b1;
                        if (r_verdict == V_KEPT) begin
                            r_count <= n_count;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_in <= i_in_data;
                end
            end
            S_PREP: begin
                r_z_max <= r_in.pos_z + rad_s;
                r_x_max <= r_in.pos_x + rad_s;
                r_x_min <= r_in.pos_x - rad_s;
                r_z_min <= r_in.pos_z - rad_s;
                r_ext   <= 1'b0;
            end
            S_TEST: begin
                r_verdict <= test_verdict;
            end
            S_MUL: begin
                // arithmetic shift by 16, keep 32 bits
                r_p <= prod[47:16];
            end
            S_DSET: begin
                r_quo  <= {p_mag, 16'd0};
                r_rem  <= 32'd0;
                r_dvs  <= z_mag;
                r_neg  <= r_p[31] ^ r_in.pos_z[31];
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= take ? trial[31:0] : {r_rem[30:0], r_quo[DIV_W-1]};
                r_quo  <= {r_quo[DIV_W-2:0], take};
                r_step <= r_step + STEP_W'(1);
            end
            S_QFIX: begin
                r_q <= qw;
            end
            S_CMP: begin
                if (!r_ext) begin
                    if (col > wmax_s) begin
                        r_verdict <= V_WRIGHT;
                    end else begin
                        r_ext <= 1'b1;
                    end
                end else begin
                    r_verdict <= (col < wmin_s) ? V_WLEFT : V_KEPT;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    r_out.accepted <= (r_verdict == V_KEPT);
                    r_out.verdict  <= r_verdict;
                    if (r_verdict == V_KEPT) begin
                        r_out.slot       <= 7'(r_count);
                        r_out.kept_count <= 8'(n_count);
                    end else begin
                        r_out.slot       <= 7'd0;
                        r_out.kept_count <= 8'(r_count);
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
